// ===== hw/rtl/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// shared types and codes of the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	localparam logic [7:0] DIR_CLEAR = 8'hFE;
	localparam logic [7:0] DIR_READ  = 8'h01;

	typedef enum logic [2:0] {
		KIND_BEGIN      = 3'd0,
		KIND_START_SENT = 3'd1,
		KIND_ADDR_SENT  = 3'd2,
		KIND_ADDR10     = 3'd3,
		KIND_STOP_SEEN  = 3'd4,
		KIND_BYTE_RX    = 3'd5,
		KIND_TX_EMPTY   = 3'd6,
		KIND_ERROR      = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_RESTART   = 3'd2,
		CMD_STOP      = 3'd3,
		CMD_NACK_STOP = 3'd4
	} bus_cmd_t;

	typedef enum logic [1:0] {
		BIRQ_KEEP    = 2'd0,
		BIRQ_ENABLE  = 2'd1,
		BIRQ_DISABLE = 2'd2
	} birq_t;

	typedef enum logic [3:0] {
		ST_OK      = 4'd0,
		ST_BUSY    = 4'd1,
		ST_ACK     = 4'd2,
		ST_ALERT   = 4'd3,
		ST_TIMEOUT = 4'd4,
		ST_OVERRUN = 4'd5,
		ST_ARB     = 4'd6,
		ST_BUS     = 4'd7,
		ST_PEC     = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		REG_TARGET_ADDRESS = 2'd0,
		REG_TX_COUNT       = 2'd1,
		REG_TX_BYTES       = 2'd2,
		REG_RX_COUNT       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  target_address;
		logic [3:0]  ntx;
		logic [63:0] tx_bytes;
		logic [7:0]  nrx;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] rx_data;
		logic       byte_done;
		logic [6:0] error_flags;
		logic       bus_master;
	} item_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_data;
		logic [2:0] bus_cmd;
		logic [1:0] buffer_irq;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] rx_position;
		logic       done_res;
		logic [3:0] status;
	} result_t;

endpackage

// ===== hw/rtl/i2c_master_transfer_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// i2c master write-then-read sequencer, one controller event in, one word out
// the event is held in the input register, then its decoded result in the result register
// throughput: one event per cycle while the result is taken, set by the state update
// the result register drains while the next event is decoded
// reset: async active low clears config, indices, phase and valid flags
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top #(
	parameter int MAX_WRITE_BYTES = 8,
	parameter int MAX_READ_BYTES  = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  rx_data,
	input  logic        byte_done,
	input  logic [6:0]  error_flags,
	input  logic        bus_master,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [7:0]  write_data,
	output logic [2:0]  bus_cmd,
	output logic [1:0]  buffer_irq,
	output logic        rx_valid,
	output logic [7:0]  rx_byte,
	output logic [7:0]  rx_position,
	output logic        done_res,
	output logic [3:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import i2cmts_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;

	i2cmts_cfg #(
		.MAX_WRITE_BYTES (MAX_WRITE_BYTES),
		.MAX_READ_BYTES  (MAX_READ_BYTES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind        <= kind;
			item_s1.rx_data     <= rx_data;
			item_s1.byte_done   <= byte_done;
			item_s1.error_flags <= error_flags;
			item_s1.bus_master  <= bus_master;
		end
		if (advance) res_q <= res;
	end

	i2cmts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid   = out_valid_q;
	assign write_valid = res_q.write_valid;
	assign write_data  = res_q.write_data;
	assign bus_cmd     = res_q.bus_cmd;
	assign buffer_irq  = res_q.buffer_irq;
	assign rx_valid    = res_q.rx_valid;
	assign rx_byte     = res_q.rx_byte;
	assign rx_position = res_q.rx_position;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending event lost during stall");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("result word changed before taken");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

endmodule

// ===== hw/rtl/i2cmts_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_cfg
// configuration registers with saturated transfer counts
// ----------------------------------------------------------------------------
module i2cmts_cfg #(
	parameter int MAX_WRITE_BYTES = 8,
	parameter int MAX_READ_BYTES  = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [63:0]         wr_data,
	output i2cmts_pkg::cfg_t    cfg
);
	import i2cmts_pkg::*;

	localparam logic [3:0] MaxTx = 4'(MAX_WRITE_BYTES);
	localparam logic [7:0] MaxRx = 8'(MAX_READ_BYTES);

	logic [7:0]  target_address_q;
	logic [3:0]  tx_count_q;
	logic [63:0] tx_bytes_q;
	logic [7:0]  rx_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= '0;
			tx_count_q       <= '0;
			tx_bytes_q       <= '0;
			rx_count_q       <= '0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_TARGET_ADDRESS: target_address_q <= wr_data[7:0];
				REG_TX_COUNT:       tx_count_q       <= wr_data[3:0];
				REG_TX_BYTES:       tx_bytes_q       <= wr_data;
				REG_RX_COUNT:       rx_count_q       <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.target_address = target_address_q;
		cfg.tx_bytes       = tx_bytes_q;
		cfg.ntx            = (tx_count_q > MaxTx) ? MaxTx : tx_count_q;
		cfg.nrx            = (rx_count_q > MaxRx) ? MaxRx : rx_count_q;
	end

endmodule

// ===== hw/rtl/i2cmts_core.sv =====
// ----------------------------------------------------------------------------
// i2cmts_core
// transfer state and event decode, one event per cycle while step is high
// ----------------------------------------------------------------------------
module i2cmts_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  i2cmts_pkg::item_t    item,
	input  i2cmts_pkg::cfg_t     cfg,
	output i2cmts_pkg::result_t  res
);
	import i2cmts_pkg::*;

	logic [3:0] write_index_q;
	logic [7:0] read_index_q;
	logic       write_phase_q;

	logic [3:0] write_index_d;
	logic [7:0] read_index_d;
	logic       write_phase_d;

	logic [3:0] wi_inc;
	logic [7:0] ri_inc;
	logic [8:0] ri_inc_p1;
	logic [2:0] top_bit;

	assign wi_inc    = write_index_q + 4'd1;
	assign ri_inc    = read_index_q + 8'd1;
	assign ri_inc_p1 = {1'b0, ri_inc} + 9'd1;

	// highest set error flag
	always_comb begin
		top_bit = '0;
		for (int b = 0; b < 7; b++) begin
			if (item.error_flags[b]) top_bit = 3'(b);
		end
	end

	always_comb begin
		res           = '0;
		write_index_d = write_index_q;
		read_index_d  = read_index_q;
		write_phase_d = write_phase_q;
		unique case (kind_t'(item.kind))
			KIND_BEGIN: begin
				write_index_d  = '0;
				read_index_d   = '0;
				write_phase_d  = (cfg.ntx != 4'd0);
				res.bus_cmd    = CMD_START;
				res.buffer_irq = BIRQ_ENABLE;
				res.status     = ST_BUSY;
			end
			KIND_START_SENT: begin
				res.write_valid = 1'b1;
				if (write_phase_q || cfg.nrx == 8'd0)
					res.write_data = cfg.target_address & DIR_CLEAR;
				else
					res.write_data = cfg.target_address | DIR_READ;
				res.buffer_irq = BIRQ_ENABLE;
			end
			KIND_ADDR_SENT: begin
				if (!write_phase_q && cfg.nrx == 8'd1) res.bus_cmd = CMD_NACK_STOP;
			end
			KIND_BYTE_RX: begin
				if (read_index_q < cfg.nrx) begin
					res.rx_valid    = 1'b1;
					res.rx_byte     = item.rx_data;
					res.rx_position = read_index_q;
					read_index_d    = ri_inc;
					if (ri_inc_p1 == {1'b0, cfg.nrx}) begin
						res.bus_cmd = CMD_NACK_STOP;
					end else if (ri_inc == cfg.nrx) begin
						res.done_res = 1'b1;
						res.status   = ST_OK;
					end
				end
			end
			KIND_TX_EMPTY: begin
				if (write_phase_q && write_index_q < cfg.ntx) begin
					res.write_valid = 1'b1;
					res.write_data  = cfg.tx_bytes[{write_index_q[2:0], 3'b000} +: 8];
					res.buffer_irq  = BIRQ_DISABLE;
					write_index_d   = wi_inc;
					if (wi_inc == cfg.ntx && cfg.nrx == 8'd0) res.bus_cmd = CMD_STOP;
				end else if (item.byte_done) begin
					if (cfg.nrx != 8'd0) begin
						if (write_phase_q) begin
							res.bus_cmd   = CMD_RESTART;
							write_phase_d = 1'b0;
						end
					end else begin
						res.done_res = 1'b1;
						res.status   = ST_OK;
					end
				end
			end
			KIND_ERROR: begin
				if (item.error_flags != 7'd0) begin
					if (item.error_flags[0] && item.bus_master) res.bus_cmd = CMD_STOP;
					res.done_res = 1'b1;
					res.status   = 4'(ST_ACK) + {1'b0, top_bit};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			read_index_q  <= '0;
			write_phase_q <= 1'b0;
		end else if (step) begin
			write_index_q <= write_index_d;
			read_index_q  <= read_index_d;
			write_phase_q <= write_phase_d;
		end
	end

	a_one_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.write_valid && res.rx_valid))
		else $error("byte written and delivered in one result");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> res.status != ST_BUSY)
		else $error("done reported with busy status");

	a_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.kind == KIND_BEGIN |=> write_index_q == 4'd0 && read_index_q == 8'd0)
		else $error("begin did not clear indices");

endmodule
